// ===== src/mqtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mqtp_pkg
// Types and constants shared by the MQTT v5 property parser modules.
// ----------------------------------------------------------------------------
package mqtp_pkg;

	typedef enum logic [2:0] {
		PH_LEN,
		PH_ID,
		PH_NUM,
		PH_VARINT,
		PH_SLEN_HI,
		PH_SLEN_LO,
		PH_DATA,
		PH_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		CLS_ONE,
		CLS_TWO,
		CLS_FOUR,
		CLS_VARINT,
		CLS_STRING,
		CLS_UNKNOWN
	} id_class_t;

	localparam logic [2:0] KIND_NUM     = 3'd0;
	localparam logic [2:0] KIND_DATA    = 3'd1;
	localparam logic [2:0] KIND_EMPTY   = 3'd2;
	localparam logic [2:0] KIND_VARERR  = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN = 3'd4;

	localparam logic [7:0] ID_PAYLOAD_FORMAT   = 8'd1;
	localparam logic [7:0] ID_MSG_EXPIRY       = 8'd2;
	localparam logic [7:0] ID_CONTENT_TYPE     = 8'd3;
	localparam logic [7:0] ID_RESPONSE_TOPIC   = 8'd8;
	localparam logic [7:0] ID_CORRELATION_DATA = 8'd9;
	localparam logic [7:0] ID_SUB_ID           = 8'd11;
	localparam logic [7:0] ID_SESSION_EXPIRY   = 8'd17;
	localparam logic [7:0] ID_AUTH_METHOD      = 8'd21;
	localparam logic [7:0] ID_AUTH_DATA        = 8'd22;
	localparam logic [7:0] ID_REQ_PROBLEM      = 8'd23;
	localparam logic [7:0] ID_WILL_DELAY       = 8'd24;
	localparam logic [7:0] ID_REQ_RESP_INFO    = 8'd25;
	localparam logic [7:0] ID_REASON_STRING    = 8'd31;
	localparam logic [7:0] ID_RECEIVE_MAX      = 8'd33;
	localparam logic [7:0] ID_TOPIC_ALIAS_MAX  = 8'd34;
	localparam logic [7:0] ID_TOPIC_ALIAS      = 8'd35;
	localparam logic [7:0] ID_USER_PROP        = 8'd38;
	localparam logic [7:0] ID_MAX_PACKET       = 8'd39;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  prop_id;
		logic [31:0] prop_value;
		logic [7:0]  data_byte;
		logic        pair_second;
		logic        last_of_element;
		logic        block_end;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== src/mqtp_front.sv =====
// ----------------------------------------------------------------------------
// mqtp_front
// Byte parser: tracks block length and property state, builds result records.
// ----------------------------------------------------------------------------
module mqtp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    in_byte,
	input  logic          frame_start,
	output logic          push,
	output mqtp_pkg::rec_t push_rec
);
	import mqtp_pkg::*;

	phase_t      ph_q;
	logic [27:0] rem_q;
	logic [7:0]  id_q;
	logic [31:0] acc_q;
	logic [15:0] left_q;
	logic [1:0]  sh_q;
	logic        pair_q;

	phase_t      e_ph;
	logic [27:0] e_rem;
	logic [7:0]  e_id;
	logic [31:0] e_acc;
	logic [15:0] e_left;
	logic [1:0]  e_sh;
	logic        e_pair;

	phase_t      n_ph;
	logic [27:0] n_rem;
	logic [7:0]  n_id;
	logic [31:0] n_acc;
	logic [15:0] n_left;
	logic [1:0]  n_sh;
	logic        n_pair;
	logic        clr;

	logic [31:0] acc_vi;
	logic [27:0] rem_dec;
	logic        last_rem;
	logic [15:0] left_dec;
	logic [15:0] slen;
	logic        emit;
	id_class_t   cls;

	function automatic logic [31:0] group_at(input logic [6:0] g, input logic [1:0] sh);
		logic [31:0] r;
		r = '0;
		case (sh)
			2'd0: r = {25'd0, g};
			2'd1: r = {18'd0, g, 7'd0};
			2'd2: r = {11'd0, g, 14'd0};
			default: r = {4'd0, g, 21'd0};
		endcase
		return r;
	endfunction

	function automatic id_class_t classify(input logic [7:0] id);
		id_class_t c;
		c = CLS_UNKNOWN;
		unique case (id) inside
			ID_PAYLOAD_FORMAT, ID_REQ_PROBLEM, ID_REQ_RESP_INFO: c = CLS_ONE;
			ID_RECEIVE_MAX, ID_TOPIC_ALIAS_MAX, ID_TOPIC_ALIAS: c = CLS_TWO;
			ID_MSG_EXPIRY, ID_SESSION_EXPIRY, ID_WILL_DELAY, ID_MAX_PACKET: c = CLS_FOUR;
			ID_SUB_ID: c = CLS_VARINT;
			ID_CONTENT_TYPE, ID_RESPONSE_TOPIC, ID_CORRELATION_DATA, ID_AUTH_METHOD,
			ID_AUTH_DATA, ID_REASON_STRING, ID_USER_PROP: c = CLS_STRING;
			default: c = CLS_UNKNOWN;
		endcase
		return c;
	endfunction

	always_comb begin
		if (frame_start) begin
			e_ph   = PH_LEN;
			e_rem  = '0;
			e_id   = '0;
			e_acc  = '0;
			e_left = '0;
			e_sh   = '0;
			e_pair = 1'b0;
		end else begin
			e_ph   = ph_q;
			e_rem  = rem_q;
			e_id   = id_q;
			e_acc  = acc_q;
			e_left = left_q;
			e_sh   = sh_q;
			e_pair = pair_q;
		end
		acc_vi   = e_acc | group_at(in_byte[6:0], e_sh);
		rem_dec  = e_rem - 28'd1;
		last_rem = (rem_dec == '0);
		left_dec = e_left - 16'd1;
		slen     = {e_left[7:0], in_byte};
		cls      = classify(in_byte);
	end

	// next state
	always_comb begin
		n_ph   = e_ph;
		n_rem  = e_rem;
		n_id   = e_id;
		n_acc  = e_acc;
		n_left = e_left;
		n_sh   = e_sh;
		n_pair = e_pair;
		clr    = 1'b0;
		if (e_ph == PH_LEN) begin
			if (in_byte[7]) begin
				if (e_sh == 2'd3) begin
					clr  = 1'b1;
				end else begin
					n_sh  = e_sh + 2'd1;
					n_acc = acc_vi;
				end
			end else if (acc_vi[27:0] == '0) begin
				clr = 1'b1;
			end else begin
				n_rem = acc_vi[27:0];
				n_acc = '0;
				n_sh  = '0;
				n_ph  = PH_ID;
			end
		end else if (e_rem != '0) begin
			n_rem = rem_dec;
			unique case (e_ph)
				PH_ID: begin
					n_id   = in_byte;
					n_acc  = '0;
					n_sh   = '0;
					n_pair = 1'b0;
					n_left = '0;
					case (cls)
						CLS_ONE: begin
							n_left = 16'd1;
							n_ph   = PH_NUM;
						end
						CLS_TWO: begin
							n_left = 16'd2;
							n_ph   = PH_NUM;
						end
						CLS_FOUR: begin
							n_left = 16'd4;
							n_ph   = PH_NUM;
						end
						CLS_VARINT: n_ph = PH_VARINT;
						CLS_STRING: n_ph = PH_SLEN_HI;
						default:    n_ph = PH_SKIP;
					endcase
				end
				PH_NUM: begin
					n_acc  = {e_acc[23:0], in_byte};
					n_left = left_dec;
					if (left_dec == '0)
						n_ph = PH_ID;
				end
				PH_VARINT: begin
					n_acc = acc_vi;
					if (in_byte[7]) begin
						if (e_sh == 2'd3)
							n_ph = PH_SKIP;
						else
							n_sh = e_sh + 2'd1;
					end else begin
						n_ph = PH_ID;
					end
				end
				PH_SLEN_HI: begin
					n_left = {8'd0, in_byte};
					n_ph   = PH_SLEN_LO;
				end
				PH_SLEN_LO: begin
					n_left = slen;
					if (slen != '0)
						n_ph = PH_DATA;
					else if (e_id == ID_USER_PROP && !e_pair) begin
						n_pair = 1'b1;
						n_ph   = PH_SLEN_HI;
					end else
						n_ph = PH_ID;
				end
				PH_DATA: begin
					n_left = left_dec;
					if (left_dec == '0) begin
						if (e_id == ID_USER_PROP && !e_pair) begin
							n_pair = 1'b1;
							n_ph   = PH_SLEN_HI;
						end else
							n_ph = PH_ID;
					end
				end
				default: ;
			endcase
			if (last_rem)
				clr = 1'b1;
		end
		if (clr) begin
			n_ph   = (e_ph == PH_LEN && in_byte[7]) ? PH_SKIP : PH_LEN;
			n_rem  = '0;
			n_id   = '0;
			n_acc  = '0;
			n_left = '0;
			n_sh   = '0;
			n_pair = 1'b0;
		end
	end

	// result record
	always_comb begin
		emit     = 1'b0;
		push_rec = '0;
		if (e_ph == PH_LEN) begin
			if (in_byte[7] && e_sh == 2'd3) begin
				emit          = 1'b1;
				push_rec.kind = KIND_VARERR;
			end else if (!in_byte[7] && acc_vi[27:0] == '0) begin
				emit               = 1'b1;
				push_rec.kind      = KIND_EMPTY;
				push_rec.block_end = 1'b1;
			end
		end else if (e_rem != '0) begin
			push_rec.block_end = last_rem;
			unique case (e_ph)
				PH_ID: begin
					if (cls == CLS_UNKNOWN) begin
						emit             = 1'b1;
						push_rec.kind    = KIND_UNKNOWN;
						push_rec.prop_id = in_byte;
					end
				end
				PH_NUM: begin
					if (left_dec == '0) begin
						emit                = 1'b1;
						push_rec.kind       = KIND_NUM;
						push_rec.prop_id    = e_id;
						push_rec.prop_value = {e_acc[23:0], in_byte};
					end
				end
				PH_VARINT: begin
					if (in_byte[7] && e_sh == 2'd3) begin
						emit             = 1'b1;
						push_rec.kind    = KIND_VARERR;
						push_rec.prop_id = e_id;
					end else if (!in_byte[7]) begin
						emit                = 1'b1;
						push_rec.kind       = KIND_NUM;
						push_rec.prop_id    = e_id;
						push_rec.prop_value = acc_vi;
					end
				end
				PH_DATA: begin
					emit                     = 1'b1;
					push_rec.kind            = KIND_DATA;
					push_rec.prop_id         = e_id;
					push_rec.data_byte       = in_byte;
					push_rec.pair_second     = e_pair;
					push_rec.last_of_element = (left_dec == '0);
				end
				default: ;
			endcase
		end
		push = take & emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_LEN;
			rem_q  <= '0;
			id_q   <= '0;
			acc_q  <= '0;
			left_q <= '0;
			sh_q   <= '0;
			pair_q <= 1'b0;
		end else if (take) begin
			ph_q   <= n_ph;
			rem_q  <= n_rem;
			id_q   <= n_id;
			acc_q  <= n_acc;
			left_q <= n_left;
			sh_q   <= n_sh;
			pair_q <= n_pair;
		end
	end

endmodule

// ===== src/mqtp_queue.sv =====
// ----------------------------------------------------------------------------
// mqtp_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module mqtp_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mqtp_pkg::rec_t  push_rec,
	input  logic            pop,
	output mqtp_pkg::rec_t  head,
	output mqtp_pkg::q_stat_t stat
);
	import mqtp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	rec_t          mem [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign head       = mem[rd_q];
	assign stat.full  = (cnt_q == FULL);
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== src/mqtp_back.sv =====
// ----------------------------------------------------------------------------
// mqtp_back
// Output register: pulls records from the queue and holds them until taken.
// ----------------------------------------------------------------------------
module mqtp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mqtp_pkg::q_stat_t q_stat,
	input  mqtp_pkg::rec_t    head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        kind,
	output logic [7:0]        prop_id,
	output logic [31:0]       prop_value,
	output logic [7:0]        data_byte,
	output logic              pair_second,
	output logic              last_of_element,
	output logic              block_end
);
	import mqtp_pkg::*;

	logic valid_q;
	rec_t rec_q;

	assign pop = !q_stat.empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || !out_stall)
			valid_q <= !q_stat.empty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= head;
	end

	assign out_valid       = valid_q;
	assign kind            = rec_q.kind;
	assign prop_id         = rec_q.prop_id;
	assign prop_value      = rec_q.prop_value;
	assign data_byte       = rec_q.data_byte;
	assign pair_second     = rec_q.pair_second;
	assign last_of_element = rec_q.last_of_element;
	assign block_end       = rec_q.block_end;

endmodule

// ===== src/mqtt5_property_parser.sv =====
// ----------------------------------------------------------------------------
// mqtt5_property_parser
// MQTT v5 property block parser: one byte in, at most one result out.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    in_byte, frame_start
//   out      output     out_valid/out_stall  kind, prop_id, prop_value,
//                                            data_byte, pair_second,
//                                            last_of_element, block_end
//
// One byte per cycle while in_stall is low; the parser state updates in the
// cycle a byte transfers. A result is queued, then held in the output register.
// in_stall is high while the result queue (QUEUE_DEPTH entries) is full.
// Reset returns the parser to reading a block length; no clearing pass.
// ----------------------------------------------------------------------------
module mqtt5_property_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  prop_id,
	output logic [31:0] prop_value,
	output logic [7:0]  data_byte,
	output logic        pair_second,
	output logic        last_of_element,
	output logic        block_end
);
	import mqtp_pkg::*;

	logic    take;
	logic    q_push;
	rec_t    q_rec;
	logic    q_pop;
	rec_t    q_head;
	q_stat_t q_stat;

	assign in_stall = q_stat.full;
	assign take     = in_valid && !in_stall;

	mqtp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.in_byte     (in_byte),
		.frame_start (frame_start),
		.push        (q_push),
		.push_rec    (q_rec)
	);

	mqtp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_rec),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	mqtp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_stat          (q_stat),
		.head            (q_head),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.prop_id         (prop_id),
		.prop_value      (prop_value),
		.data_byte       (data_byte),
		.pair_second     (pair_second),
		.last_of_element (last_of_element),
		.block_end       (block_end)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into full queue");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty");

	a_empty_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EMPTY |-> block_end && prop_id == 8'd0)
		else $error("empty block result malformed");

	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |->
		data_byte == 8'd0 && !pair_second && !last_of_element)
		else $error("data fields set on non-data result");

endmodule
